@@ rtl/core/arv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arv_pkg;

  // Operation codes carried by a word.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register byte offsets.
  localparam logic [2:0] REG_VOLUME = 3'd0;
  localparam logic [3:0] VOLUME_RESET = 4'd9;

  // Division by nine as a multiplication by ceil(2^23 / 9) and a shift.
  // The product magnitude stays below 2^20, well inside the exact range.
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [19:0] RECIP_MUL = 20'd932068;

  localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;
  localparam logic [7:0] PWM_NEUTRAL = 8'd128;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;

  // One classified word, already scaled when it is a push.
  typedef struct packed {
    logic        operation;
    logic        batch_start;
    logic [15:0] sample;
  } word_t;

  typedef struct packed {
    logic [7:0]  pwm_level;
    logic        level_valid;
    logic        ring_was_empty;
    logic        sample_stored;
    logic [10:0] fill_count;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/arv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arv_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  wire                 in_operation,
  input  wire  [15:0]         in_sample_in,
  input  wire                 in_batch_start,
  input  wire  [3:0]          volume,
  output logic                word_valid,
  output arv_pkg::word_t      word,
  input  wire                 queue_full
);

  logic        v1_r, v1_nxt;
  logic        op1_r, bs1_r, neg1_r;
  logic [19:0] mag1_r;
  logic        v2_r, v2_nxt;
  logic        op2_r, bs2_r, neg2_r;
  logic [15:0] quot2_r;

  logic               advance;
  logic signed [20:0] prod;
  logic [20:0]        prod_mag;
  logic [39:0]        recip_prod;
  logic [15:0]        scaled;

  // The whole pipeline moves together; it stops only when its last word
  // cannot enter the queue.
  assign advance = !v2_r || !queue_full;
  assign full    = !advance;

  assign prod       = $signed(in_sample_in) * $signed({1'b0, volume});
  assign prod_mag   = prod[20] ? 21'(-prod) : 21'(prod);
  assign recip_prod = {20'd0, mag1_r} * {20'd0, arv_pkg::RECIP_MUL};

  assign v1_nxt = push && !full;
  assign v2_nxt = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1_r   <= in_operation;
      bs1_r   <= in_batch_start;
      neg1_r  <= prod[20];
      mag1_r  <= prod_mag[19:0];
      op2_r   <= op1_r;
      bs2_r   <= bs1_r;
      neg2_r  <= neg1_r;
      quot2_r <= recip_prod[arv_pkg::RECIP_SHIFT +: 16];
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  always_comb begin
    if (neg2_r) begin
      if (quot2_r > 16'd32768) begin
        scaled = arv_pkg::SAMPLE_MIN;
      end else begin
        scaled = 16'(~quot2_r + 16'd1);
      end
    end else begin
      if (quot2_r > 16'd32767) begin
        scaled = arv_pkg::SAMPLE_MAX;
      end else begin
        scaled = quot2_r;
      end
    end
  end

  assign word_valid       = v2_r;
  assign word.operation   = op2_r;
  assign word.batch_start = bs2_r;
  assign word.sample      = scaled;

endmodule

`default_nettype wire

@@ rtl/core/arv_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arv_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  input  arv_pkg::word_t  wr_word,
  output logic            q_full,
  output logic            rd_valid,
  output arv_pkg::word_t  rd_word,
  input  wire             rd_take
);

  arv_pkg::word_t                      slots_r [arv_pkg::QUEUE_DEPTH];
  logic [arv_pkg::QUEUE_AW-1:0]        wp_r, wp_nxt;
  logic [arv_pkg::QUEUE_AW-1:0]        rp_r, rp_nxt;
  logic [arv_pkg::QUEUE_AW:0]          cnt_r, cnt_nxt;
  logic                                wr_en, rd_en;

  assign q_full   = (cnt_r == (arv_pkg::QUEUE_AW + 1)'(arv_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = slots_r[rp_r];

  assign wr_en = wr_valid && !q_full;
  assign rd_en = rd_take && rd_valid;

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wp_r] <= wr_word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/arv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arv_back #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned BATCH_LEN  = 256
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  arv_pkg::word_t   q_word,
  output logic             q_take,
  output logic             res_valid,
  output arv_pkg::result_t res,
  input  wire              res_pop
);

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned PTR_W  = $clog2(2 * RING_DEPTH);
  localparam int unsigned FW     = (PTR_W > 11) ? PTR_W : 11;
  localparam int unsigned LIMIT  = (RING_DEPTH > BATCH_LEN) ? RING_DEPTH - BATCH_LEN : 0;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] SPAN_P  = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] LIMIT_P = PTR_W'(LIMIT);

  logic [15:0] ring_mem [RING_DEPTH];

  arv_pkg::back_state_t state_r, state_nxt;
  logic [PTR_W-1:0]     wr_r, wr_nxt;
  logic [PTR_W-1:0]     rd_r, rd_nxt;
  logic                 admit_r, admit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  arv_pkg::result_t     out_r, out_nxt;
  logic [10:0]          pend_fill_r, pend_fill_nxt;
  logic [15:0]          rd_data_r;

  logic [PTR_W-1:0] fill;
  logic             mem_we, mem_re;
  logic             store;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[ADDR_W-1:0];
  endfunction

  // Pointers run over twice the depth so that full and empty differ.
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (p == SPAN_P) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [10:0] fill_field(input logic [PTR_W-1:0] f);
    logic [FW-1:0] e;
    e = FW'(f);
    return e[10:0];
  endfunction

  assign fill = (wr_r >= rd_r) ? wr_r - rd_r : PTR_W'(wr_r + SPAN_P + 1'b1 - rd_r);

  // A word is taken only when the result register will be free for it.
  assign q_take = q_valid && (state_r == arv_pkg::BK_IDLE) && (!out_valid_r || res_pop);

  always_comb begin
    state_nxt     = state_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    admit_nxt     = admit_r;
    out_valid_nxt = out_valid_r && !res_pop;
    out_nxt       = out_r;
    pend_fill_nxt = pend_fill_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    store         = 1'b0;
    case (state_r)
      arv_pkg::BK_IDLE: begin
        if (q_take) begin
          if (q_word.operation == arv_pkg::OP_PUSH) begin
            if (q_word.batch_start) begin
              admit_nxt = (fill < LIMIT_P);
            end
            store         = admit_nxt && (fill < DEPTH_P);
            mem_we        = store;
            wr_nxt        = store ? step_ptr(wr_r) : wr_r;
            out_valid_nxt = 1'b1;
            out_nxt       = '{pwm_level: 8'd0, level_valid: 1'b0, ring_was_empty: 1'b0,
                              sample_stored: store,
                              fill_count: fill_field(store ? fill + 1'b1 : fill)};
          end else if (fill != '0) begin
            mem_re        = 1'b1;
            rd_nxt        = step_ptr(rd_r);
            pend_fill_nxt = fill_field(fill - 1'b1);
            state_nxt     = arv_pkg::BK_READ;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{pwm_level: arv_pkg::PWM_NEUTRAL, level_valid: 1'b1,
                              ring_was_empty: 1'b1, sample_stored: 1'b0,
                              fill_count: fill_field(fill)};
          end
        end
      end
      arv_pkg::BK_READ: begin
        // Adding 32768 flips the sign bit, so the level is the top byte with
        // its most significant bit inverted.
        out_valid_nxt = 1'b1;
        out_nxt       = '{pwm_level: {~rd_data_r[15], rd_data_r[14:8]}, level_valid: 1'b1,
                          ring_was_empty: 1'b0, sample_stored: 1'b0,
                          fill_count: pend_fill_r};
        state_nxt     = arv_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = arv_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arv_pkg::BK_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      admit_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      admit_r     <= admit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    pend_fill_r <= pend_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_of(wr_r)] <= q_word.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= ring_mem[slot_of(rd_r)];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

@@ rtl/core/audio_ring_volume_pwm.sv @@
// Path: a push's word passes the two scaling stages, the queue and the back end to reach
// the result ports; a tick that pops a stored sample also waits on the registered ring read.
// Throughput: one push per cycle unless the queue or result port holds it back; a tick that
// reads the ring holds the back end in its read state for the single registered read port.
// Reset: pointers, batch flag, queue and pipeline are cleared and volume returns to nine;
// the ring contents are not cleared, as only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module audio_ring_volume_pwm #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned BATCH_LEN  = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  output logic        full,
  input  wire         in_operation,
  input  wire  [15:0] in_sample_in,
  input  wire         in_batch_start,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  out_pwm_level,
  output logic        out_level_valid,
  output logic        out_ring_was_empty,
  output logic        out_sample_stored,
  output logic [10:0] out_fill_count,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]       volume_r, volume_nxt;
  logic             word_valid, queue_full;
  arv_pkg::word_t   front_word, q_word;
  logic             q_valid, q_take;
  logic             res_valid;
  arv_pkg::result_t res;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign volume_nxt = (cfg_wr && paddr == arv_pkg::REG_VOLUME) ? pwdata[3:0] : volume_r;
  assign prdata     = (paddr == arv_pkg::REG_VOLUME) ? {28'd0, volume_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= arv_pkg::VOLUME_RESET;
    end else begin
      volume_r <= volume_nxt;
    end
  end

  arv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_sample_in   (in_sample_in),
    .in_batch_start (in_batch_start),
    .volume         (volume_r),
    .word_valid     (word_valid),
    .word           (front_word),
    .queue_full     (queue_full)
  );

  arv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (word_valid),
    .wr_word  (front_word),
    .q_full   (queue_full),
    .rd_valid (q_valid),
    .rd_word  (q_word),
    .rd_take  (q_take)
  );

  arv_back #(
    .RING_DEPTH (RING_DEPTH),
    .BATCH_LEN  (BATCH_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_take    (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty              = !res_valid;
  assign out_pwm_level      = res.pwm_level;
  assign out_level_valid    = res.level_valid;
  assign out_ring_was_empty = res.ring_was_empty;
  assign out_sample_stored  = res.sample_stored;
  assign out_fill_count     = res.fill_count;

endmodule

`default_nettype wire

@@ rtl/core/arv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arv_checker #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire [7:0]  out_pwm_level,
  input wire        out_level_valid,
  input wire        out_ring_was_empty,
  input wire        out_sample_stored,
  input wire [10:0] out_fill_count
);

  // A word is either a tick result or a push result, never both.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_level_valid && out_sample_stored))
    else $error("word flags both a level and a stored sample");

  // An empty-ring tick carries the neutral level and an empty count.
  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_ring_was_empty) |->
      (out_level_valid && out_pwm_level == 8'd128 && out_fill_count == 11'd0))
    else $error("empty-ring tick word is inconsistent");

  // A stored sample leaves at least one sample in the ring.
  a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_sample_stored) |-> (out_fill_count != 11'd0))
    else $error("stored sample with zero fill count");

  // The fill count never exceeds the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (32'(out_fill_count) <= 32'(RING_DEPTH)))
    else $error("fill count above ring depth");

  // No word is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

endmodule

bind audio_ring_volume_pwm arv_checker #(.RING_DEPTH(RING_DEPTH)) u_arv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .out_pwm_level      (out_pwm_level),
  .out_level_valid    (out_level_valid),
  .out_ring_was_empty (out_ring_was_empty),
  .out_sample_stored  (out_sample_stored),
  .out_fill_count     (out_fill_count)
);

`default_nettype wire
